### hw/rtl/fmm_pkg.sv
// ----------------------------------------------------------------------------
// fmm_pkg
// Shared types and single-precision arithmetic for the 4x4 matrix multiply.
// ----------------------------------------------------------------------------
package fmm_pkg;

  localparam int unsigned NumCols = 4;
  localparam logic [31:0] NanCanon = 32'h7FC0_0000;
  localparam logic [1:0]  LastRow  = 2'd3;

  // Read addresses from the back end into the operand stores.
  typedef struct packed {
    logic [3:0] a_addr;
    logic [3:0] b_addr;
  } rd_req_t;

  typedef logic [NumCols-1:0][31:0] row_t;

  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] cnt;
    cnt = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        cnt = 6'(47 - i);
      end
    end
    return cnt;
  endfunction

  function automatic logic [4:0] lzc27(logic [26:0] v);
    logic [4:0] cnt;
    cnt = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) begin
        cnt = 5'(26 - i);
      end
    end
    return cnt;
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic               s;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]         ea, eb, ef;
    logic [23:0]        ma, mb;
    logic [47:0]        p, n;
    logic [5:0]         lz;
    logic signed [10:0] e;
    logic [10:0]        sh;
    logic               st, rnd;
    logic [30:0]        mag;
    logic [31:0]        r;
    s      = a[31] ^ b[31];
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    p      = 48'(ma) * 48'(mb);
    lz     = lzc48(p);
    e      = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126
           - $signed({5'b0, lz});
    n      = p << lz;
    st     = 1'b0;
    ef     = e[7:0];
    sh     = 11'd0;
    mag    = 31'd0;
    rnd    = 1'b0;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      r = NanCanon;
    end else if (a_inf || b_inf) begin
      r = {s, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      r = {s, 31'd0};
    end else if (e >= 11'sd255) begin
      r = {s, 8'hFF, 23'd0};
    end else begin
      if (e <= 11'sd0) begin
        sh = 11'(11'sd1 - e);
        ef = 8'd0;
        if (sh > 11'd47) begin
          st = |n;
          n  = 48'd0;
        end else begin
          st = |(n & ((48'h1 << sh[5:0]) - 48'h1));
          n  = n >> sh[5:0];
        end
      end
      st  = st | (|n[22:0]);
      rnd = n[23] & (st | n[24]);
      mag = {ef, n[46:24]} + 31'(rnd);
      r   = {s, mag};
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [31:0] x, y;
    logic [7:0]  exe, eye, d;
    logic [26:0] mx, my, nm;
    logic [27:0] sum;
    logic [4:0]  lz;
    logic [8:0]  e;
    logic        st, rnd;
    logic [30:0] mag;
    logic [31:0] r;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    exe = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    eye = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx  = {x[30:23] != 8'd0, x[22:0], 3'b000};
    my  = {y[30:23] != 8'd0, y[22:0], 3'b000};
    d   = exe - eye;
    if (d > 8'd26) begin
      st = |my;
      my = 27'd0;
    end else begin
      st = |(my & ((27'h1 << d[4:0]) - 27'h1));
      my = my >> d[4:0];
    end
    my[0] = my[0] | st;
    sum = (x[31] ^ y[31]) ? ({1'b0, mx} - {1'b0, my}) : ({1'b0, mx} + {1'b0, my});
    lz  = lzc27(sum[26:0]);
    nm  = sum[26:0];
    e   = 9'd0;
    mag = 31'd0;
    rnd = 1'b0;
    if (sum[27]) begin
      nm    = sum[27:1];
      nm[0] = nm[0] | sum[0];
      e     = 9'(exe) + 9'd1;
    end else if ({3'b0, lz} < exe) begin
      nm = sum[26:0] << lz;
      e  = 9'(exe) - 9'(lz);
    end else begin
      nm = sum[26:0] << (exe - 8'd1);
      e  = 9'd0;
    end
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      r = NanCanon;
    end else if (a_inf) begin
      r = a;
    end else if (b_inf) begin
      r = b;
    end else if (sum == 28'd0) begin
      r = {a[31] & b[31], 31'd0};
    end else if (e >= 9'd255) begin
      r = {x[31], 8'hFF, 23'd0};
    end else begin
      rnd = nm[2] & ((|nm[1:0]) | nm[3]);
      mag = {e[7:0], nm[25:3]} + 31'(rnd);
      r   = {x[31], mag};
    end
    return r;
  endfunction

endpackage

### hw/rtl/fmm_jobq.sv
// ----------------------------------------------------------------------------
// fmm_jobq
// One-entry request queue between the row loader and the compute sequencer.
// ----------------------------------------------------------------------------
module fmm_jobq (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic pop_i,
  output logic full_o
);

  logic full_q, full_d;

  // Hold the pending request until the sequencer takes it.
  always_comb begin
    full_d = full_q;
    if (pop_i) begin
      full_d = 1'b0;
    end
    if (push_i) begin
      full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  assign full_o = full_q;

endmodule

### hw/rtl/fmm_front.sv
// ----------------------------------------------------------------------------
// fmm_front
// Row loader: writes rows of A and B into the stores and counts them.
// ----------------------------------------------------------------------------
module fmm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  fmm_pkg::row_t    a_row_i,
  input  fmm_pkg::row_t    b_row_i,
  input  fmm_pkg::rd_req_t rd_i,
  output logic [31:0]      a_data_o,
  output logic [31:0]      b_data_o,
  output logic             push_o
);
  import fmm_pkg::*;

  logic [31:0] a_q [16];
  logic [31:0] b_q [16];
  logic [1:0]  rows_q, rows_d;

  assign rows_d = accept_i ? rows_q + 2'd1 : rows_q;
  assign push_o = accept_i && (rows_q == LastRow);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 2'd0;
    end else begin
      rows_q <= rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int c = 0; c < NumCols; c++) begin
        a_q[{rows_q, 2'(c)}] <= a_row_i[c];
        b_q[{rows_q, 2'(c)}] <= b_row_i[c];
      end
    end
  end

  assign a_data_o = a_q[rd_i.a_addr];
  assign b_data_o = b_q[rd_i.b_addr];

endmodule

### hw/rtl/fmm_back.sv
// ----------------------------------------------------------------------------
// fmm_back
// Compute sequencer: one multiply or add per cycle, emits product rows.
// ----------------------------------------------------------------------------
module fmm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_i,
  output logic             pop_o,
  output logic             active_o,
  output fmm_pkg::rd_req_t rd_o,
  input  logic [31:0]      a_data_i,
  input  logic [31:0]      b_data_i,
  output fmm_pkg::row_t    p_o,
  output logic [1:0]       row_o,
  output logic             last_o,
  output logic             valid_o
);
  import fmm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ADD0, ST_ADD1, ST_ADD2, ST_EMIT
  } state_e;

  state_e      state_q;
  logic [1:0]  i_q, j_q, k_q;
  logic [31:0] m_q [NumCols];
  logic [31:0] s0_q, s1_q;
  row_t        p_q;
  logic        valid_q;

  assign rd_o.a_addr = {i_q, k_q};
  assign rd_o.b_addr = {k_q, j_q};
  assign pop_o       = (state_q == ST_IDLE) && job_i;
  assign active_o    = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= 2'd0;
      j_q     <= 2'd0;
      k_q     <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (job_i) begin
            i_q     <= 2'd0;
            j_q     <= 2'd0;
            k_q     <= 2'd0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          k_q <= k_q + 2'd1;
          if (k_q == LastRow) begin
            state_q <= ST_ADD0;
          end
        end
        ST_ADD0: state_q <= ST_ADD1;
        ST_ADD1: state_q <= ST_ADD2;
        ST_ADD2: begin
          j_q <= j_q + 2'd1;
          if (j_q == LastRow) begin
            valid_q <= 1'b1;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_EMIT: begin
          valid_q <= 1'b0;
          i_q     <= i_q + 2'd1;
          state_q <= (i_q == LastRow) ? ST_IDLE : ST_MUL;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_MUL:  m_q[k_q]  <= fp_mul(a_data_i, b_data_i);
      ST_ADD0: s0_q      <= fp_add(m_q[0], m_q[1]);
      ST_ADD1: s1_q      <= fp_add(m_q[2], m_q[3]);
      ST_ADD2: p_q[j_q]  <= fp_add(s0_q, s1_q);
      default: ;
    endcase
  end

  assign p_o     = p_q;
  assign row_o   = i_q;
  assign last_o  = (i_q == LastRow);
  assign valid_o = valid_q;

endmodule

### hw/rtl/float_matrix_multiply_4x4_top.sv
// ----------------------------------------------------------------------------
// float_matrix_multiply_4x4_top
// 4x4 single-precision matrix product P = A*B, loaded one row pair at a time.
// ----------------------------------------------------------------------------
// Each request carries row r of A and row r of B, rows in order 0..3. The
// first three requests are taken back to back, one per cycle, and give no
// result. The fourth starts the product: busy stays high while it is
// handed to the sequencer and worked off row by row, as one shared
// multiplier and the adders are sequenced over the 16 elements, with
// seven operations per element (four products, then the two pair sums,
// then the final sum), and each finished product row is shown for one
// cycle. The row strobe valid_o cannot be held off, so the receiver must
// take every row in the cycle it appears. Rows come out in order with
// out_row_o, and is_last_o marks row 3.
// Rounding is to nearest even with subnormals kept; every NaN result is the
// canonical quiet NaN 0x7FC00000.
// ----------------------------------------------------------------------------
module float_matrix_multiply_4x4_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] a_col0_i,
  input  logic [31:0] a_col1_i,
  input  logic [31:0] a_col2_i,
  input  logic [31:0] a_col3_i,
  input  logic [31:0] b_col0_i,
  input  logic [31:0] b_col1_i,
  input  logic [31:0] b_col2_i,
  input  logic [31:0] b_col3_i,
  output logic        valid_o,
  output logic [31:0] p_col0_o,
  output logic [31:0] p_col1_o,
  output logic [31:0] p_col2_o,
  output logic [31:0] p_col3_o,
  output logic [1:0]  out_row_o,
  output logic        is_last_o
);
  import fmm_pkg::*;

  logic    accept;
  logic    push, pop, job_full, back_active;
  rd_req_t rd_req;
  logic [31:0] a_data, b_data;
  row_t    a_row, b_row, p_row;

  // Take a request whenever neither a product is queued nor one is running.
  assign busy   = job_full || back_active;
  assign accept = start && !busy;

  assign a_row = {a_col3_i, a_col2_i, a_col1_i, a_col0_i};
  assign b_row = {b_col3_i, b_col2_i, b_col1_i, b_col0_i};

  // Front: store the row pair, advance the row count, queue the product.
  fmm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .a_row_i  (a_row),
    .b_row_i  (b_row),
    .rd_i     (rd_req),
    .a_data_o (a_data),
    .b_data_o (b_data),
    .push_o   (push)
  );

  fmm_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (job_full)
  );

  // Back: walk the elements and drop each finished row on the outputs.
  fmm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job_full),
    .pop_o    (pop),
    .active_o (back_active),
    .rd_o     (rd_req),
    .a_data_i (a_data),
    .b_data_i (b_data),
    .p_o      (p_row),
    .row_o    (out_row_o),
    .last_o   (is_last_o),
    .valid_o  (valid_o)
  );

  assign p_col0_o = p_row[0];
  assign p_col1_o = p_row[1];
  assign p_col2_o = p_row[2];
  assign p_col3_o = p_row[3];

`ifndef SYNTH
  // A row never appears while the block is idle.
  a_valid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result row while idle");

  // The last row ends the product: no row follows in the next cycle.
  a_last_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_last_o) |=> !valid_o)
    else $error("row after last row");

  // Queuing a product blocks further requests at once.
  a_push_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> busy)
    else $error("request taken while product pending");
`endif

endmodule
